@@ src/sphl_pkg.sv @@
`default_nettype none

package sphl_pkg;

  // Running sums and the iterative remainder unit
  localparam int SUM_W   = 30;
  localparam int MOD_W   = 9;
  localparam int CNT_W   = $clog2(SUM_W + 1);
  localparam int BYTE_W  = 8;
  localparam int SALT_W  = 16;
  localparam int G_W     = 16;
  localparam int LEN_W   = 6;
  localparam int SLOT_W  = 8;

  // Request kinds carried in the low bits of s_tuser
  typedef enum logic [1:0] {
    ACT_SALT  = 2'd0,
    ACT_G     = 2'd1,
    ACT_KEY   = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic REG_NUM_G       = 1'b0;
  localparam logic REG_MAX_KEY_LEN = 1'b1;

endpackage

`default_nettype wire

@@ src/sphl_ram.sv @@
`default_nettype none

module sphl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [WIDTH-1:0]       wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output logic      [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/sphl_mod.sv @@
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module sphl_mod
  import sphl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [MOD_W-1:0] modulus,
  output logic                  done,
  output logic      [MOD_W-1:0] rem
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] dvd;
  logic [MOD_W-1:0] m;
  logic [MOD_W:0]   trial;
  logic             ge;
  logic [MOD_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[SUM_W-1]};
    ge       = trial >= {1'b0, m};
    rem_next = ge ? MOD_W'(trial - {1'b0, m}) : MOD_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: load operands on start, shift one bit in per busy cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      m   <= modulus;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

@@ src/salted_perfect_hash_lookup.sv @@
`default_nettype none

// Salted two-table perfect hash lookup. Load requests (kind 0: salt pair at
// an index, kind 1: G entry at an index) write the tables directly. A key
// then arrives one byte per request (kind 2); each byte takes one salt-table
// read and two multiply-accumulate steps sharing one 16x8 multiplier. The
// request carrying tlast finishes the key: the shared restoring remainder
// unit runs three times (sum one mod num_g, sum two mod num_g, then
// (G1+G2) mod num_g), with the two G-table reads before the third run, and
// then the result is offered on the master side. A key longer than the
// length limit (the smaller of max_key_len and SALT_DEPTH) reports too_long
// with slot 0 and skips the hash. Loads and key bytes keep being taken while
// a result waits to be taken; only the next final request waits for the
// output register. A num_g of 0 acts as 1. Tables start undefined and must
// be loaded before use.
module salted_perfect_hash_lookup
  import sphl_pkg::*;
#(
  parameter int SALT_DEPTH = 32,
  parameter int G_DEPTH    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] index, [23:8] salt_one, [39:24] salt_two, [55:40] g_value,
  // [63:56] key_byte
  input  wire logic [63:0] s_tdata,
  // [1:0] action, [2] byte_present
  input  wire logic [2:0]  s_tuser,
  input  wire logic        s_tlast,   // key_last
  // Results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] slot
  output logic             m_tuser,   // [0] too_long
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int SAW = (SALT_DEPTH > 1) ? $clog2(SALT_DEPTH) : 1;
  localparam int GAW = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_SALT_RD = 10'b00_0000_0010,
    ST_MAC_ONE = 10'b00_0000_0100,
    ST_MAC_TWO = 10'b00_0000_1000,
    ST_MOD_ONE = 10'b00_0001_0000,
    ST_MOD_TWO = 10'b00_0010_0000,
    ST_G_RD1   = 10'b00_0100_0000,
    ST_G_RD2   = 10'b00_1000_0000,
    ST_MOD_SUM = 10'b01_0000_0000,
    ST_RESULT  = 10'b10_0000_0000
  } state_t;

  // Request fields
  action_t             in_action;
  logic [7:0]          in_index;
  logic [SALT_W-1:0]   in_salt_one;
  logic [SALT_W-1:0]   in_salt_two;
  logic [G_W-1:0]      in_g_value;
  logic [BYTE_W-1:0]   in_key_byte;
  logic                in_present;

  assign in_action   = action_t'(s_tuser[1:0]);
  assign in_present  = s_tuser[2];
  assign in_index    = s_tdata[7:0];
  assign in_salt_one = s_tdata[23:8];
  assign in_salt_two = s_tdata[39:24];
  assign in_g_value  = s_tdata[55:40];
  assign in_key_byte = s_tdata[63:56];

  // Configuration
  logic [MOD_W-1:0] num_g;
  logic [LEN_W-1:0] max_key_len;
  logic [MOD_W-1:0] modulus;

  assign cfg_ready = 1'b1;
  assign modulus   = (num_g == '0) ? MOD_W'(1) : num_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_g       <= MOD_W'(1);
      max_key_len <= LEN_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_G:       num_g       <= cfg_data[MOD_W-1:0];
        REG_MAX_KEY_LEN: max_key_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Key state
  state_t            state, state_next;
  logic [SUM_W-1:0]  sum_one;
  logic [SUM_W-1:0]  sum_two;
  logic [LEN_W-1:0]  byte_count;
  logic              over;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [MOD_W-1:0]  idx_one;
  logic [G_W-1:0]    g_one;

  // Datapath nets
  logic                accept;
  logic                is_key;
  logic                take_byte;
  logic                set_over;
  logic                end_key;
  logic [31:0]         limit;
  logic [2*SALT_W-1:0] salt_rd;
  logic [G_W-1:0]      g_rd;
  logic                salt_wr_en;
  logic                salt_rd_en;
  logic                g_wr_en;
  logic                g_rd_en;
  logic [GAW-1:0]      g_rd_addr;
  logic                g_in_one;
  logic                g_in_two;
  logic [SALT_W-1:0]   mul_salt;
  logic [SALT_W+BYTE_W-1:0] product;
  logic [G_W:0]        g_sum;
  logic                mod_start;
  logic [SUM_W-1:0]    mod_dvd;
  logic                mod_done;
  logic [MOD_W-1:0]    mod_rem;
  logic                out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign limit     = (32'(max_key_len) < SALT_DEPTH) ? 32'(max_key_len) : SALT_DEPTH;
  assign is_key    = accept && (in_action == ACT_KEY);
  assign take_byte = is_key && in_present && !over && (32'(byte_count) < limit);
  assign set_over  = is_key && in_present && !over && !(32'(byte_count) < limit);

  // Table writes go straight from the request; salt read fetches this byte's pair
  assign salt_wr_en = accept && (in_action == ACT_SALT) && (32'(in_index) < SALT_DEPTH);
  assign g_wr_en    = accept && (in_action == ACT_G) && (32'(in_index) < G_DEPTH);
  assign salt_rd_en = take_byte;

  // G reads: first index at end of second remainder, second one after it
  assign g_in_one  = 32'(idx_one) < G_DEPTH;
  assign g_in_two  = 32'(mod_rem) < G_DEPTH;
  assign g_rd_en   = (state == ST_MOD_TWO && mod_done) || (state == ST_G_RD1);
  assign g_rd_addr = (state == ST_G_RD1) ? GAW'(mod_rem) : GAW'(idx_one);

  sphl_ram #(
    .WIDTH (2 * SALT_W),
    .DEPTH (SALT_DEPTH)
  ) u_salt_ram (
    .clk     (clk),
    .wr_en   (salt_wr_en),
    .wr_addr (SAW'(in_index)),
    .wr_data ({in_salt_two, in_salt_one}),
    .rd_en   (salt_rd_en),
    .rd_addr (SAW'(byte_count)),
    .rd_data (salt_rd)
  );

  sphl_ram #(
    .WIDTH (G_W),
    .DEPTH (G_DEPTH)
  ) u_g_ram (
    .clk     (clk),
    .wr_en   (g_wr_en),
    .wr_addr (GAW'(in_index)),
    .wr_data (in_g_value),
    .rd_en   (g_rd_en),
    .rd_addr (g_rd_addr),
    .rd_data (g_rd)
  );

  // One multiplier serves both sums on successive cycles
  assign mul_salt = (state == ST_MAC_ONE) ? salt_rd[SALT_W-1:0] : salt_rd[2*SALT_W-1:SALT_W];
  assign product  = mul_salt * byte_q;
  assign g_sum    = {1'b0, g_one} + {1'b0, (g_in_two ? g_rd : G_W'(0))};

  // Key ends on a last mark: an overlong key skips the hash entirely
  always_comb begin
    end_key   = 1'b0;
    mod_start = 1'b0;
    mod_dvd   = sum_one;
    unique case (state)
      ST_IDLE:    end_key = is_key && s_tlast && !take_byte;
      ST_MAC_TWO: end_key = last_q;
      ST_MOD_ONE: begin
        mod_start = mod_done;
        mod_dvd   = sum_two;
      end
      ST_G_RD2: begin
        mod_start = 1'b1;
        mod_dvd   = SUM_W'(g_sum);
      end
      default: ;
    endcase
    if (end_key && !(over || set_over)) begin
      mod_start = 1'b1;
    end
  end

  sphl_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .modulus  (modulus),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_byte) begin
          state_next = ST_SALT_RD;
        end else if (end_key) begin
          state_next = (over || set_over) ? ST_RESULT : ST_MOD_ONE;
        end
      end
      ST_SALT_RD: state_next = ST_MAC_ONE;
      ST_MAC_ONE: state_next = ST_MAC_TWO;
      ST_MAC_TWO: begin
        if (end_key) begin
          state_next = over ? ST_RESULT : ST_MOD_ONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MOD_ONE: if (mod_done) state_next = ST_MOD_TWO;
      ST_MOD_TWO: if (mod_done) state_next = ST_G_RD1;
      ST_G_RD1:   state_next = ST_G_RD2;
      ST_G_RD2:   state_next = ST_MOD_SUM;
      ST_MOD_SUM: if (mod_done) state_next = ST_RESULT;
      ST_RESULT:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sum_one    <= '0;
      sum_two    <= '0;
      byte_count <= '0;
      over       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      // Offer a finished result, or drop the one just taken
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (set_over) begin
        over <= 1'b1;
      end
      if (state == ST_MAC_ONE) begin
        sum_one <= sum_one + SUM_W'(product);
      end
      if (state == ST_MAC_TWO) begin
        sum_two    <= sum_two + SUM_W'(product);
        byte_count <= byte_count + 1'b1;
      end
      // Hand the result over and drop the key state
      if (state == ST_RESULT && out_free) begin
        sum_one    <= '0;
        sum_two    <= '0;
        byte_count <= '0;
        over       <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (is_key) begin
      byte_q <= in_key_byte;
      last_q <= s_tlast;
    end
    if (state == ST_MOD_ONE && mod_done) begin
      idx_one <= mod_rem;
    end
    if (state == ST_G_RD1) begin
      g_one <= g_in_one ? g_rd : G_W'(0);
    end
    if (state == ST_RESULT && out_free) begin
      m_tdata <= over ? SLOT_W'(0) : mod_rem[SLOT_W-1:0];
      m_tuser <= over;
    end
  end

endmodule

`default_nettype wire

@@ verif/salted_perfect_hash_lookup_tb.sv @@
`timescale 1ns / 1ps

module salted_perfect_hash_lookup_tb;
  import sphl_pkg::*;

  localparam int SALT_DEPTH     = 32;
  localparam int G_DEPTH        = 256;
  localparam int SETTLE_CYCLES  = 150;     // covers the finishing pass
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASE_ITEMS    = 130;

  // One request as the block sees it, fields in the order of the stream
  typedef struct packed {
    action_t     action;
    logic [7:0]  index;
    logic [15:0] salt_one;
    logic [15:0] salt_two;
    logic [15:0] g_value;
    logic [7:0]  key_byte;
    logic        byte_present;
    logic        key_last;
  } hash_req_t;

  typedef struct packed {
    logic [7:0] slot;
    logic       too_long;
  } slot_result_t;

  // Tracks tables, sums and registers; holds the slots still owed by the block
  class hash_slot_predictor;
    logic [15:0]  salt_one_tab [SALT_DEPTH];
    logic [15:0]  salt_two_tab [SALT_DEPTH];
    logic [15:0]  g_tab [G_DEPTH];
    logic [29:0]  sum_one;
    logic [29:0]  sum_two;
    int unsigned  byte_count;
    bit           over;
    logic [8:0]   num_g;
    logic [5:0]   max_key_len;
    slot_result_t expected_slots[$];
    int           mismatch_count;

    function new();
      sum_one = '0;
      sum_two = '0;
      byte_count = 0;
      over = 1'b0;
      num_g = 9'd1;
      max_key_len = 6'd32;
      mismatch_count = 0;
    endfunction

    function void write_register(logic idx, logic [8:0] value);
      if (idx == REG_NUM_G) num_g = value;
      else max_key_len = value[5:0];
    endfunction

    function void take_request(hash_req_t r);
      int unsigned  limit;
      int unsigned  modulus;
      int unsigned  idx_one;
      int unsigned  idx_two;
      int unsigned  g_one;
      int unsigned  g_two;
      slot_result_t res;
      case (r.action)
        ACT_SALT: begin
          if (r.index < SALT_DEPTH) begin
            salt_one_tab[r.index] = r.salt_one;
            salt_two_tab[r.index] = r.salt_two;
          end
        end
        ACT_G: begin
          if (r.index < G_DEPTH) g_tab[r.index] = r.g_value;
        end
        ACT_KEY: begin
          if (r.byte_present && !over) begin
            limit = (max_key_len < SALT_DEPTH) ? max_key_len : SALT_DEPTH;
            if (byte_count < limit) begin
              sum_one = 30'(32'(sum_one) + 32'(salt_one_tab[byte_count]) * 32'(r.key_byte));
              sum_two = 30'(32'(sum_two) + 32'(salt_two_tab[byte_count]) * 32'(r.key_byte));
              byte_count++;
            end else begin
              over = 1'b1;
            end
          end
          if (r.key_last) begin
            if (over) begin
              res.slot = 8'd0;
              res.too_long = 1'b1;
            end else begin
              // a zero modulus acts as one; indexes past the table read zero
              modulus = (num_g == 0) ? 1 : num_g;
              idx_one = sum_one % modulus;
              idx_two = sum_two % modulus;
              g_one = (idx_one < G_DEPTH) ? g_tab[idx_one] : 0;
              g_two = (idx_two < G_DEPTH) ? g_tab[idx_two] : 0;
              res.slot = 8'((g_one + g_two) % modulus);
              res.too_long = 1'b0;
            end
            expected_slots.push_back(res);
            sum_one = '0;
            sum_two = '0;
            byte_count = 0;
            over = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void match_result(logic [7:0] slot, logic too_long);
      slot_result_t want;
      if (expected_slots.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual slot %0d too_long %0b",
                 $time, slot, too_long);
        return;
      end
      want = expected_slots.pop_front();
      if (slot !== want.slot) begin
        mismatch_count++;
        $display("%0t: slot mismatch, expected %0d, actual %0d", $time, want.slot, slot);
      end
      if (too_long !== want.too_long) begin
        mismatch_count++;
        $display("%0t: too_long mismatch, expected %0b, actual %0b",
                 $time, want.too_long, too_long);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;

  hash_slot_predictor predictor;
  int  cycle_count = 0;
  int  counted_requests = 0;
  int  rx_hold_requests = 0;   // bumped by the stimulus, served by the result sink
  bit  tx_burst = 1'b0;

  salted_perfect_hash_lookup #(
    .SALT_DEPTH(SALT_DEPTH),
    .G_DEPTH   (G_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a correct run ends far below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every result taken from the master side against the oldest slot owed
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) predictor.match_result(m_tdata, m_tuser);
  end

  // Result sink: random back-pressure, bursts of full readiness, and the long
  // hold-off when the stimulus asks for it
  initial begin : result_sink
    int stall_left;
    int hold_seen;
    bit rx_burst;
    stall_left = 0;
    hold_seen = 0;
    rx_burst = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != rx_hold_requests) begin
        hold_seen = rx_hold_requests;
        stall_left = RX_HOLD_CYCLES;
      end
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_burst) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(15, 60);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Mostly short gaps, now and then a long one; none at all in a burst
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Every field random; callers then pin down the ones that matter
  function automatic hash_req_t noise_req();
    hash_req_t r;
    r.action = action_t'($urandom_range(0, 3));
    r.index = 8'($urandom);
    r.salt_one = 16'($urandom);
    r.salt_two = 16'($urandom);
    r.g_value = 16'($urandom);
    r.key_byte = 8'($urandom);
    r.byte_present = 1'($urandom);
    r.key_last = 1'($urandom);
    return r;
  endfunction

  function automatic hash_req_t key_req(logic [7:0] kb, logic present, logic last);
    hash_req_t r;
    r = noise_req();
    r.action = ACT_KEY;
    r.key_byte = kb;
    r.byte_present = present;
    r.key_last = last;
    return r;
  endfunction

  function automatic hash_req_t salt_req(logic [7:0] idx, logic [15:0] a, logic [15:0] b);
    hash_req_t r;
    r = noise_req();
    r.action = ACT_SALT;
    r.index = idx;
    r.salt_one = a;
    r.salt_two = b;
    return r;
  endfunction

  function automatic hash_req_t g_req(logic [7:0] idx, logic [15:0] v);
    hash_req_t r;
    r = noise_req();
    r.action = ACT_G;
    r.index = idx;
    r.g_value = v;
    return r;
  endfunction

  // Offer one request and hold it until taken; tvalid stays high into the
  // next request when there is no gap
  task automatic send_request(input hash_req_t r);
    int gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {r.key_byte, r.g_value, r.salt_two, r.salt_one, r.index};
    s_tuser <= {r.byte_present, r.action};
    s_tlast <= r.key_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predictor.take_request(r);
    if (r.action != ACT_SPARE && !(r.action == ACT_KEY && !r.byte_present && !r.key_last))
      counted_requests++;
  endtask

  task automatic write_register(input logic idx, input logic [8:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    predictor.write_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed slot, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (predictor.expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_load();
    logic [7:0] idx;
    if ($urandom_range(0, 1) == 0) begin
      idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, SALT_DEPTH - 1))
                                       : 8'($urandom_range(SALT_DEPTH, 255));
      send_request(salt_req(idx, 16'($urandom), 16'($urandom)));
    end else begin
      send_request(g_req(8'($urandom), 16'($urandom)));
    end
  endtask

  // One well-formed key with random content, salted with loads and no-ops
  task automatic send_random_key(input int limit);
    int  key_len;
    int  r;
    bit  split_end;
    hash_req_t spare;
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) send_random_load();
    r = $urandom_range(0, 99);
    if (r < 10) key_len = 0;
    else if (r < 70) key_len = $urandom_range(1, (limit < 8) ? ((limit < 1) ? 1 : limit) : 8);
    else if (r < 85) key_len = $urandom_range(0, limit);
    else key_len = limit + $urandom_range(1, 6);
    split_end = (key_len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < key_len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_random_load();
      else if (r < 13) send_request(key_req(8'($urandom), 1'b0, 1'b0));
      else if (r < 16) begin
        spare = noise_req();
        spare.action = ACT_SPARE;
        send_request(spare);
      end
      send_request(key_req(8'($urandom), 1'b1, (i == key_len - 1) && !split_end));
    end
    if (split_end) send_request(key_req(8'($urandom), 1'b0, 1'b1));
  endtask

  task automatic run_phase(input logic [8:0] ng, input logic [5:0] mkl, input bit long_hold);
    int base;
    int limit;
    settle();
    if ($urandom_range(0, 1) == 0) begin
      write_register(REG_NUM_G, ng);
      write_register(REG_MAX_KEY_LEN, {3'($urandom), mkl});
    end else begin
      write_register(REG_MAX_KEY_LEN, {3'($urandom), mkl});
      write_register(REG_NUM_G, ng);
    end
    limit = (mkl < SALT_DEPTH) ? mkl : SALT_DEPTH;
    // receiver holds off while short keys keep coming: the block must stall
    if (long_hold) rx_hold_requests++;
    base = counted_requests;
    while (counted_requests - base < PHASE_ITEMS) send_random_key(limit);
  endtask

  initial begin
    predictor = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every table entry first so no later read sees an unwritten entry;
    // salt entries 0 and 1 and G entries 0 and 255 carry the extremes
    for (int i = 0; i < SALT_DEPTH; i++) begin
      if (i == 0) send_request(salt_req(8'(i), 16'hFFFF, 16'hFFFF));
      else if (i == 1) send_request(salt_req(8'(i), 16'h0000, 16'h0000));
      else send_request(salt_req(8'(i), 16'($urandom), 16'($urandom)));
    end
    for (int i = 0; i < G_DEPTH; i++) begin
      if (i == 0 || i == G_DEPTH - 1) send_request(g_req(8'(i), 16'hFFFF));
      else send_request(g_req(8'(i), 16'($urandom)));
    end

    // Empty key under the reset registers
    send_request(key_req(8'($urandom), 1'b0, 1'b1));

    settle();
    write_register(REG_NUM_G, 9'd256);
    write_register(REG_MAX_KEY_LEN, 9'd3);
    // Top byte value throughout, last mark on the byte itself
    send_request(key_req(8'd255, 1'b1, 1'b0));
    send_request(key_req(8'd255, 1'b1, 1'b0));
    send_request(key_req(8'd255, 1'b1, 1'b1));
    // Zero byte, then a separate end item
    send_request(key_req(8'd0, 1'b1, 1'b0));
    send_request(key_req(8'($urandom), 1'b0, 1'b1));
    // Loads, no-ops and a spare action inside a key
    send_request(key_req(8'd7, 1'b1, 1'b0));
    send_request(g_req(8'd0, 16'h0000));
    send_request(key_req(8'($urandom), 1'b0, 1'b0));
    begin : spare_item
      hash_req_t spare;
      spare = noise_req();
      spare.action = ACT_SPARE;
      spare.key_last = 1'b1;
      send_request(spare);
    end
    send_request(salt_req(8'd32, 16'($urandom), 16'($urandom)));
    send_request(salt_req(8'd255, 16'($urandom), 16'($urandom)));
    send_request(salt_req(8'd2, 16'($urandom), 16'($urandom)));
    send_request(key_req(8'd200, 1'b1, 1'b0));
    send_request(key_req(8'd9, 1'b1, 1'b1));
    // One byte past the limit, last mark on the byte
    for (int i = 1; i <= 4; i++) send_request(key_req(8'(i), 1'b1, i == 4));
    // Two bytes past the limit, then a separate end item
    for (int i = 1; i <= 5; i++) send_request(key_req(8'(10 * i), 1'b1, 1'b0));
    send_request(key_req(8'($urandom), 1'b0, 1'b1));

    // Random phases, each under its own register setting
    run_phase(9'd256, 6'd32, 1'b1);
    run_phase(9'd1,   6'd32, 1'b0);
    run_phase(9'd0,   6'd5,  1'b0);
    run_phase(9'd511, 6'd63, 1'b0);
    run_phase(9'd97,  6'd0,  1'b0);
    run_phase(9'd300, 6'd33, 1'b0);
    run_phase(9'd2,   6'd1,  1'b0);
    run_phase(9'($urandom_range(1, 256)), 6'($urandom_range(0, 32)), 1'b0);

    settle();
    if (predictor.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
